// File: hw/rtl/ssr_pkg.sv
// Shared types, constants and register codes of the stepper speed ramp channel.
package ssr_pkg;

  // Default widths of the step time and rpm readback datapaths
  localparam int TIME_BITS_DEF = 20;
  localparam int RPM_BITS_DEF  = 24;

  // Fixed field and register widths
  localparam int FACTOR_W   = 24;
  localparam int RPM_W      = 16;
  localparam int STIME_W    = 20;
  localparam int VALUE_W    = 20;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_TDATA_W = 24;

  // Divider: 24-bit dividend, 32-bit divisor, one extra bit for compares
  localparam int DEN_W  = 32;
  localparam int WIDE_W = DEN_W + 1;

  // Register reset values
  localparam int FACTOR_RST    = 150000;
  localparam int RAMP_RST      = 10;
  localparam int RPM_MIN_RST   = 15;
  localparam int RPM_MAX_RST   = 1500;
  localparam int STIME_MIN_RST = 100;
  localparam int STIME_MAX_RST = 10000;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 3'd0,
    MODE_RAMP     = 3'd1,
    MODE_SET_TIME = 3'd2,
    MODE_SET_RPM  = 3'd3,
    MODE_ENABLE   = 3'd4,
    MODE_POWER    = 3'd5,
    MODE_DIR      = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR    = 3'd0,
    CFG_RAMP      = 3'd1,
    CFG_RPM_MIN   = 3'd2,
    CFG_RPM_MAX   = 3'd3,
    CFG_STIME_MIN = 3'd4,
    CFG_STIME_MAX = 3'd5
  } cfg_idx_e;

  // Divisor source for the shared divider
  typedef enum logic [1:0] {
    DEN_CUR   = 2'd0,
    DEN_NR    = 2'd1,
    DEN_VALUE = 2'd2,
    DEN_TGT   = 2'd3
  } den_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     apply_simple;
    logic     ramp_finish;
    logic     rpm_finish;
    logic     rb_direct;
    logic     rb_load;
    logic     out_load;
    logic     div_start;
    den_sel_e den_sel;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              value_zero;
    logic              cur_eq_tgt;
    logic              rb_trivial;
    logic              div_done;
    logic              out_busy;
  } status_t;

endpackage

// File: hw/rtl/stepper_speed_ramp.sv
// Top level of one stepper channel with speed ramp: controller, datapath and config port.
// One item is taken at a time, and every division runs on one shared serial divider.
// A tick, enable, power, direction or set-step-time item needs one division, the rpm
// readback; when the target is parked or zero the readback needs no division. A set-rpm
// item with a nonzero value first divides for the new target, then for the readback
// (none when the new target lands at the maximum). A ramp update needs two more
// divisions, rpm of the current step time, then step time of the new rpm, and none for
// the readback with a parked target. A ramp update whose current step time already
// equals the target costs the same as a tick. The result shows up in the same cycle as
// the next item can be taken. A result sits in an output register, so the next item is
// accepted while it waits to be taken. The block stalls only when a second result is
// ready before the first has been transferred.
// Config writes are always taken and should only be issued while the channel is idle.
module stepper_speed_ramp #(
  parameter int TIME_BITS = ssr_pkg::TIME_BITS_DEF,
  parameter int RPM_BITS  = ssr_pkg::RPM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // value [19:0], flag [20], zero pad
  input  logic [ssr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // mode [2:0]
  input  logic [ssr_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // step_level, dir_level, power_pin_n, running, now_step_time, goal_step_time,
  // rpm_readback, zero pad
  output logic [((4 + 2 * TIME_BITS + RPM_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int OUT_W       = 4 + 2 * TIME_BITS + RPM_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  ssr_pkg::cmd_t    cmd;
  ssr_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  ssr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ssr_datapath #(
    .TIME_BITS  (TIME_BITS),
    .RPM_BITS   (RPM_BITS),
    .OUT_TDATA_W(OUT_TDATA_W)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

// File: hw/rtl/ssr_div.sv
// Restoring serial divider, one quotient bit per cycle, zero divisor flagged.
module ssr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ssr_pkg::FACTOR_W-1:0]  num_i,
  input  logic [ssr_pkg::DEN_W-1:0]     den_i,
  output logic [ssr_pkg::FACTOR_W-1:0]  quo_o,
  output logic                          dz_o,
  output logic                          done_o
);

  localparam int CNT_W = $clog2(ssr_pkg::FACTOR_W + 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [ssr_pkg::FACTOR_W-1:0]  quo_q;
  logic [ssr_pkg::DEN_W-1:0]     rem_q;
  logic [ssr_pkg::DEN_W-1:0]     den_q;
  logic                          dz_q;

  logic [ssr_pkg::WIDE_W-1:0]    shifted;
  logic [ssr_pkg::WIDE_W-1:0]    diff;
  logic                          ge;
  logic [ssr_pkg::DEN_W-1:0]     rem_nx;

  always_comb begin
    shifted = {rem_q, quo_q[ssr_pkg::FACTOR_W-1]};
    ge      = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
    rem_nx  = ge ? diff[ssr_pkg::DEN_W-1:0] : shifted[ssr_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ssr_pkg::FACTOR_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      dz_q  <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[ssr_pkg::FACTOR_W-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign dz_o   = dz_q;
  assign done_o = done_q;

endmodule

// File: hw/rtl/ssr_datapath.sv
// Datapath: config registers, channel state, ramp arithmetic, divider and result register.
module ssr_datapath #(
  parameter int TIME_BITS   = ssr_pkg::TIME_BITS_DEF,
  parameter int RPM_BITS    = ssr_pkg::RPM_BITS_DEF,
  parameter int OUT_TDATA_W = 72
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [ssr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [ssr_pkg::MODE_W-1:0]       s_axis_tuser,
  input  logic                             m_axis_tready,
  output logic                             m_axis_tvalid,
  output logic [OUT_TDATA_W-1:0]           m_axis_tdata,
  input  ssr_pkg::cmd_t                    cmd_i,
  output ssr_pkg::status_t                 status_o
);

  localparam int WW = ssr_pkg::WIDE_W;
  localparam int DW = ssr_pkg::DEN_W;

  // Config registers
  logic [ssr_pkg::FACTOR_W-1:0] factor_q;
  logic [ssr_pkg::RPM_W-1:0]    ramp_q, rmin_q, rmax_q;
  logic [ssr_pkg::STIME_W-1:0]  stmin_q, stmax_q;

  // Latched item
  logic [ssr_pkg::MODE_W-1:0]   mode_q;
  logic [ssr_pkg::VALUE_W-1:0]  value_q;
  logic                         flag_q;

  // Channel state
  logic [TIME_BITS-1:0] cur_q, cur_d, tgt_q, tgt_d, cnt_q, cnt_d;
  logic                 en_q, en_d, pw_q, pw_d, dir_q, dir_d, step_q, step_d;
  logic [RPM_BITS-1:0]  rb_q, rb_d;
  logic [OUT_TDATA_W-1:0] out_q;
  logic                 out_valid_q, out_valid_d;

  // Divider
  logic [ssr_pkg::FACTOR_W-1:0] quo;
  logic                         dz, div_done;
  logic [DW-1:0]                den;

  logic [WW-1:0] cur_w, tgt_w, stmin_w, stmax_w;
  logic          cur_gt_tgt, cur_lt_tgt;
  logic [DW-1:0] rpm32, nr_up, nr_dn, nr;
  logic [WW-1:0] rpm_sum, dn_lim;
  logic [WW-1:0] nt, t1, t2;
  logic [TIME_BITS-1:0] ramp_new, park_v, clamp_out;
  logic [WW-1:0] clamp_in;
  logic [TIME_BITS-1:0] cnt_inc;

  always_comb begin
    cur_w      = WW'(cur_q);
    tgt_w      = WW'(tgt_q);
    stmin_w    = WW'(stmin_q);
    stmax_w    = WW'(stmax_q);
    cur_gt_tgt = cur_w > tgt_w;
    cur_lt_tgt = cur_w < tgt_w;
    park_v     = TIME_BITS'(stmax_q);

    // rpm of the current step time, zero divisor reads as all ones
    rpm32   = dz ? '1 : DW'(quo);
    rpm_sum = WW'(rpm32) + WW'(ramp_q);
    nr_up   = (rpm_sum > WW'(rmax_q)) ? DW'(rmax_q) : rpm_sum[DW-1:0];
    dn_lim  = WW'(ramp_q) + WW'(rmin_q);
    nr_dn   = (WW'(rpm32) < dn_lim) ? DW'(rmin_q) : (rpm32 - DW'(ramp_q));
    nr      = cur_gt_tgt ? nr_up : nr_dn;

    case (cmd_i.den_sel)
      ssr_pkg::DEN_CUR:   den = DW'(cur_q);
      ssr_pkg::DEN_NR:    den = nr;
      ssr_pkg::DEN_VALUE: den = DW'(value_q);
      ssr_pkg::DEN_TGT:   den = DW'(tgt_q);
      default:            den = DW'(cur_q);
    endcase

    // New step time: at least one unit of change unless already at the target, never past it
    nt = dz ? {1'b0, {DW{1'b1}}} : WW'(quo);
    if (cur_gt_tgt) begin
      t1 = (nt >= cur_w) ? (cur_w - 1'b1) : nt;
      t2 = (t1 < tgt_w) ? tgt_w : t1;
    end else if (cur_lt_tgt) begin
      t1 = (nt <= cur_w) ? (cur_w + 1'b1) : nt;
      t2 = (t1 > tgt_w) ? tgt_w : t1;
    end else begin
      t1 = cur_w;
      t2 = cur_w;
    end
    ramp_new = t2[TIME_BITS-1:0];

    // Lower bound is tested first
    clamp_in = cmd_i.rpm_finish ? WW'(quo) : WW'(value_q);
    if (clamp_in < stmin_w) begin
      clamp_out = TIME_BITS'(stmin_q);
    end else if (clamp_in > stmax_w) begin
      clamp_out = TIME_BITS'(stmax_q);
    end else begin
      clamp_out = clamp_in[TIME_BITS-1:0];
    end

    cnt_inc = cnt_q + 1'b1;
  end

  always_comb begin
    cur_d  = cur_q;
    tgt_d  = tgt_q;
    cnt_d  = cnt_q;
    en_d   = en_q;
    pw_d   = pw_q;
    dir_d  = dir_q;
    step_d = step_q;
    rb_d   = rb_q;

    if (cmd_i.apply_simple) begin
      case (mode_q)
        ssr_pkg::MODE_TICK: begin
          if (cnt_inc >= cur_q) begin
            cnt_d = '0;
            if (en_q) step_d = ~step_q;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        ssr_pkg::MODE_SET_TIME: tgt_d = clamp_out;
        ssr_pkg::MODE_SET_RPM:  tgt_d = park_v;
        ssr_pkg::MODE_ENABLE: begin
          en_d = flag_q;
          if (!flag_q) tgt_d = park_v;
        end
        ssr_pkg::MODE_POWER: begin
          pw_d = flag_q;
          if (!flag_q) tgt_d = park_v;
        end
        ssr_pkg::MODE_DIR: dir_d = flag_q;
        default: ;
      endcase
    end

    if (cmd_i.rpm_finish) begin
      tgt_d = clamp_out;
      en_d  = 1'b1;
    end

    if (cmd_i.ramp_finish) begin
      cur_d = ramp_new;
      if (WW'(ramp_new) >= stmax_w) begin
        en_d  = 1'b0;
        tgt_d = park_v;
      end
    end

    if (cmd_i.rb_direct) begin
      rb_d = (tgt_w >= stmax_w) ? '0 : '1;
    end else if (cmd_i.rb_load) begin
      rb_d = RPM_BITS'(quo);
    end

    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q    <= ssr_pkg::FACTOR_W'(ssr_pkg::FACTOR_RST);
      ramp_q      <= ssr_pkg::RPM_W'(ssr_pkg::RAMP_RST);
      rmin_q      <= ssr_pkg::RPM_W'(ssr_pkg::RPM_MIN_RST);
      rmax_q      <= ssr_pkg::RPM_W'(ssr_pkg::RPM_MAX_RST);
      stmin_q     <= ssr_pkg::STIME_W'(ssr_pkg::STIME_MIN_RST);
      stmax_q     <= ssr_pkg::STIME_W'(ssr_pkg::STIME_MAX_RST);
      cur_q       <= TIME_BITS'(ssr_pkg::STIME_MAX_RST);
      tgt_q       <= TIME_BITS'(ssr_pkg::STIME_MAX_RST);
      cnt_q       <= '0;
      en_q        <= 1'b0;
      pw_q        <= 1'b0;
      dir_q       <= 1'b1;
      step_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ssr_pkg::CFG_FACTOR:    factor_q <= cfg_data_i[ssr_pkg::FACTOR_W-1:0];
          ssr_pkg::CFG_RAMP:      ramp_q   <= cfg_data_i[ssr_pkg::RPM_W-1:0];
          ssr_pkg::CFG_RPM_MIN:   rmin_q   <= cfg_data_i[ssr_pkg::RPM_W-1:0];
          ssr_pkg::CFG_RPM_MAX:   rmax_q   <= cfg_data_i[ssr_pkg::RPM_W-1:0];
          ssr_pkg::CFG_STIME_MIN: stmin_q  <= cfg_data_i[ssr_pkg::STIME_W-1:0];
          ssr_pkg::CFG_STIME_MAX: stmax_q  <= cfg_data_i[ssr_pkg::STIME_W-1:0];
          default: ;
        endcase
      end
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      cnt_q       <= cnt_d;
      en_q        <= en_d;
      pw_q        <= pw_d;
      dir_q       <= dir_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q  <= s_axis_tuser;
      value_q <= s_axis_tdata[ssr_pkg::VALUE_W-1:0];
      flag_q  <= s_axis_tdata[ssr_pkg::VALUE_W];
    end
    rb_q <= rb_d;
    if (cmd_i.out_load) begin
      out_q <= OUT_TDATA_W'({rb_q, tgt_q, cur_q, en_q, ~pw_q, dir_q, step_q});
    end
  end

  ssr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (factor_q),
    .den_i  (den),
    .quo_o  (quo),
    .dz_o   (dz),
    .done_o (div_done)
  );

  assign status_o.mode       = mode_q;
  assign status_o.value_zero = (value_q == '0);
  assign status_o.cur_eq_tgt = (cur_q == tgt_q);
  assign status_o.rb_trivial = (tgt_w >= stmax_w) || (tgt_q == '0);
  assign status_o.div_done   = div_done;
  assign status_o.out_busy   = out_valid_q && !m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// File: hw/rtl/ssr_ctrl.sv
// Controller: sequences item decode, divisions, state update and result hand-off.
module ssr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  ssr_pkg::status_t status_i,
  output ssr_pkg::cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_DIV_RPM  = 8'b0000_0100,
    S_DIV_NT   = 8'b0000_1000,
    S_DIV_TGT  = 8'b0001_0000,
    S_RB_START = 8'b0010_0000,
    S_DIV_RB   = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.den_sel = ssr_pkg::DEN_CUR;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.mode)
          ssr_pkg::MODE_RAMP: begin
            if (status_i.cur_eq_tgt) begin
              cmd_o.ramp_finish = 1'b1;
              state_d = S_RB_START;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.den_sel   = ssr_pkg::DEN_CUR;
              state_d = S_DIV_RPM;
            end
          end
          ssr_pkg::MODE_SET_RPM: begin
            if (status_i.value_zero) begin
              cmd_o.apply_simple = 1'b1;
              state_d = S_RB_START;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.den_sel   = ssr_pkg::DEN_VALUE;
              state_d = S_DIV_TGT;
            end
          end
          default: begin
            cmd_o.apply_simple = 1'b1;
            state_d = S_RB_START;
          end
        endcase
      end
      S_DIV_RPM: begin
        if (status_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.den_sel   = ssr_pkg::DEN_NR;
          state_d = S_DIV_NT;
        end
      end
      S_DIV_NT: begin
        if (status_i.div_done) begin
          cmd_o.ramp_finish = 1'b1;
          state_d = S_RB_START;
        end
      end
      S_DIV_TGT: begin
        if (status_i.div_done) begin
          cmd_o.rpm_finish = 1'b1;
          state_d = S_RB_START;
        end
      end
      S_RB_START: begin
        if (status_i.rb_trivial) begin
          cmd_o.rb_direct = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.den_sel   = ssr_pkg::DEN_TGT;
          state_d = S_DIV_RB;
        end
      end
      S_DIV_RB: begin
        if (status_i.div_done) begin
          cmd_o.rb_load = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for a free result register
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);

endmodule

// File: hw/rtl/ssr_checker.sv
// Port-level checker for the stepper speed ramp channel, bound to the top level.
module ssr_checker #(
  parameter int OUT_TDATA_W = 72
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic last_step_q;
  logic have_q;

  // step level of the last transferred result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_step_q <= 1'b1;
      have_q      <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_step_q <= m_axis_tdata[0];
      have_q      <= 1'b1;
    end
  end

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in progress");

  // the step pin only toggles on a tick while enabled
  a_step_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && have_q && (m_axis_tdata[0] != last_step_q) |-> m_axis_tdata[3])
    else $error("step level changed while not running");

endmodule

bind stepper_speed_ramp ssr_checker #(.OUT_TDATA_W(OUT_TDATA_W)) u_ssr_checker (.*);
